>>> rtl/pfpa_pkg.sv
package pfpa_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int FRAME_LENGTH_DEF = 20;

  localparam logic [7:0] HDR0 = 8'h16;
  localparam logic [7:0] HDR1 = 8'h11;
  localparam logic [7:0] HDR2 = 8'h0B;

  // Ring of readings and the averaging arithmetic
  localparam int RING_SIZE = 5;
  localparam int RING_AW   = $clog2(RING_SIZE);
  localparam int PM_W      = 16;
  localparam int SUM_W     = $clog2(RING_SIZE * (2 ** PM_W - 1) + 1);
  localparam int AVG_W     = 20;

  // floor(16*x/5) == (x * RECIP_5) >> RECIP_SHIFT, exact for every window sum
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 21;
  localparam logic [RECIP_W-1:0] RECIP_5 = 23'd6710887;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_BAD_SUM = 2'd2
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [PM_W-1:0]   pm;
  } frame_res_t;

  typedef struct packed {
    status_t           status;
    logic [PM_W-1:0]   pm;
    logic              updated;
    logic [AVG_W-1:0]  avg;
  } result_t;

endpackage

>>> rtl/pfpa_ram.sv
module pfpa_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 5,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/pfpa_frame.sv
module pfpa_frame #(
  parameter int BUFFER_DEPTH = pfpa_pkg::BUFFER_DEPTH_DEF,
  parameter int FRAME_LENGTH = pfpa_pkg::FRAME_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_take,
  input  logic                 frame_end,
  input  logic [7:0]           data_byte,
  output pfpa_pkg::frame_res_t res
);

  localparam int CW = $clog2(BUFFER_DEPTH);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    hdr_r [3];
  logic [7:0]    hdr_nxt [3];
  logic [7:0]    rd_r [2];
  logic [7:0]    rd_nxt [2];
  logic [7:0]    sum_r, sum_nxt;
  logic          in_frame;

  assign in_frame = 32'(cnt_r) < 32'(FRAME_LENGTH);

  always_comb begin
    cnt_nxt = cnt_r;
    hdr_nxt = hdr_r;
    rd_nxt  = rd_r;
    sum_nxt = sum_r;
    if (frame_end) begin
      cnt_nxt = '0;
      hdr_nxt = '{default: 8'h00};
      rd_nxt  = '{default: 8'h00};
      sum_nxt = '0;
    end else if (byte_take) begin
      if (cnt_r < CW'(3)) begin
        hdr_nxt[cnt_r[1:0]] = data_byte;
      end else if (cnt_r == CW'(5)) begin
        rd_nxt[0] = data_byte;
      end else if (cnt_r == CW'(6)) begin
        rd_nxt[1] = data_byte;
      end
      if (in_frame) begin
        sum_nxt = sum_r + data_byte;
      end
      // buffer full: drop the whole frame
      if (cnt_r == CW'(BUFFER_DEPTH - 1)) begin
        cnt_nxt = '0;
        hdr_nxt = '{default: 8'h00};
        rd_nxt  = '{default: 8'h00};
        sum_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      hdr_r <= '{default: 8'h00};
      rd_r  <= '{default: 8'h00};
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      hdr_r <= hdr_nxt;
      rd_r  <= rd_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_comb begin
    res.pm = '0;
    if (hdr_r[0] != pfpa_pkg::HDR0 || hdr_r[1] != pfpa_pkg::HDR1 ||
        hdr_r[2] != pfpa_pkg::HDR2) begin
      res.status = pfpa_pkg::ST_BAD_HDR;
    end else if (sum_r != 8'h00) begin
      res.status = pfpa_pkg::ST_BAD_SUM;
    end else begin
      res.status = pfpa_pkg::ST_OK;
      res.pm     = {rd_r[0], rd_r[1]};
    end
  end

endmodule

>>> rtl/pfpa_avg.sv
module pfpa_avg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 s0_valid,
  input  pfpa_pkg::frame_res_t s0_res,
  output logic                 res_valid,
  output pfpa_pkg::result_t    res
);

  localparam int AW = pfpa_pkg::RING_AW;
  localparam int PW = pfpa_pkg::PM_W;
  localparam int SW = pfpa_pkg::SUM_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(pfpa_pkg::RING_SIZE - 1);

  logic [AW-1:0]                  slot_r;
  logic                           s0_ok, rd_en;
  logic                           s1_valid_r, s1_upd_r, s1_ok, wr_en;
  pfpa_pkg::frame_res_t           s1_res_r;
  logic [AW-1:0]                  s1_slot_r;
  logic [pfpa_pkg::RING_SIZE-1:0] vld_r;
  logic [PW-1:0]                  rdata, old_val;
  logic [SW-1:0]                  sum_r, sum_nxt;
  logic                           s2_valid_r, s2_upd_r;
  pfpa_pkg::frame_res_t           s2_res_r;
  logic [SW-1:0]                  s2_sum_r;
  logic [pfpa_pkg::PROD_W-1:0]    prod;

  assign s0_ok = s0_res.status == pfpa_pkg::ST_OK;
  assign rd_en = adv && s0_valid && s0_ok;

  // Stage 0: read the slot about to be overwritten
  pfpa_ram #(
    .W     (PW),
    .DEPTH (pfpa_pkg::RING_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_slot_r),
    .wdata (s1_res_r.pm),
    .re    (rd_en),
    .raddr (slot_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (rd_en) begin
      slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_res_r  <= s0_res;
      s1_slot_r <= slot_r;
      s1_upd_r  <= s0_ok && (slot_r == LAST_SLOT);
      s2_res_r  <= s1_res_r;
      s2_upd_r  <= s1_upd_r;
      s2_sum_r  <= sum_nxt;
    end
  end

  // Stage 1: window sum = sum - old entry + new reading, write back
  assign old_val = vld_r[s1_slot_r] ? rdata : '0;
  assign s1_ok   = s1_valid_r && (s1_res_r.status == pfpa_pkg::ST_OK);
  assign wr_en   = adv && s1_ok;
  assign sum_nxt = s1_ok ? (sum_r - SW'(old_val) + SW'(s1_res_r.pm)) : sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      sum_r <= '0;
    end else if (wr_en) begin
      vld_r[s1_slot_r] <= 1'b1;
      sum_r            <= sum_nxt;
    end
  end

  // Stage 2: divide by five through the reciprocal
  assign prod = pfpa_pkg::PROD_W'(s2_sum_r) * pfpa_pkg::PROD_W'(pfpa_pkg::RECIP_5);

  assign res_valid   = s2_valid_r;
  assign res.status  = s2_res_r.status;
  assign res.pm      = s2_res_r.pm;
  assign res.updated = s2_upd_r;
  assign res.avg     = prod[pfpa_pkg::RECIP_SHIFT +: pfpa_pkg::AVG_W];

endmodule

>>> rtl/pm25_frame_parser_averager.sv
// Serial particle sensor frame parser with a five-reading PM2.5 average.
// Each frame-end transaction yields its result transaction through the stage 1,
// stage 2 and output registers; byte transactions yield none.
// Throughput: one transaction per cycle when no held result stalls the input, set by
//   the single read and write port of the reading ring that each frame end visits once.
// Reset: rst_n is synchronous, active low; clears the frame buffer, ring, average.
module pm25_frame_parser_averager #(
  parameter int BUFFER_DEPTH = pfpa_pkg::BUFFER_DEPTH_DEF,
  parameter int FRAME_LENGTH = pfpa_pkg::FRAME_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_pm25_reading,
  output logic        out_avg_updated,
  output logic        out_avg_valid,
  output logic [19:0] out_avg_pm25_q4
);

  logic                      adv, take, byte_take, frame_end;
  pfpa_pkg::frame_res_t      frame_res;
  logic                      res_valid;
  pfpa_pkg::result_t         res;

  logic                      out_valid_r;
  pfpa_pkg::status_t         status_r;
  logic [pfpa_pkg::PM_W-1:0] pm_r;
  logic                      upd_r;
  logic                      avg_ready_r;
  logic [pfpa_pkg::AVG_W-1:0] avg_r;

  // The whole pipeline advances together whenever the output register is free
  // or being emptied; the only back-pressure is a held result transaction.
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign take      = in_valid && adv;
  assign byte_take = take && (in_action == pfpa_pkg::ACT_BYTE);
  assign frame_end = take && (in_action == pfpa_pkg::ACT_END);

  // Frame buffer: header, reading bytes and running checksum in registers.
  // Status is ready combinationally at the frame-end transaction.
  pfpa_frame #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .frame_end (frame_end),
    .data_byte (in_data_byte),
    .res       (frame_res)
  );

  // Ring of readings in RAM: read the outgoing entry, update the window sum,
  // write back, then divide by five; the average is flagged as updated on wrap.
  pfpa_avg u_avg (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s0_valid  (frame_end),
    .s0_res    (frame_res),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register; the published average lives here so that every later
  // result shows the latest one, in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      avg_ready_r <= 1'b0;
      avg_r       <= '0;
    end else if (adv) begin
      out_valid_r <= res_valid;
      if (res_valid && res.updated) begin
        avg_ready_r <= 1'b1;
        avg_r       <= res.avg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      status_r <= res.status;
      pm_r     <= res.pm;
      upd_r    <= res.updated;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = status_r;
  assign out_pm25_reading = pm_r;
  assign out_avg_updated  = upd_r;
  assign out_avg_valid    = avg_ready_r;
  assign out_avg_pm25_q4  = avg_r;

endmodule

>>> rtl/pfpa_checker.sv
module pfpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_frame_status,
  input logic [15:0] out_pm25_reading,
  input logic        out_avg_updated,
  input logic        out_avg_valid,
  input logic [19:0] out_avg_pm25_q4
);

  // input back-pressure only comes from a held result transaction
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status != pfpa_pkg::ST_OK |->
      out_pm25_reading == 16'd0 && !out_avg_updated)
    else $error("rejected frame carries a reading or an average update");

  a_upd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_avg_updated |-> out_avg_valid)
    else $error("average update without average valid");

  a_avg_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_avg_valid |=> out_avg_valid)
    else $error("average valid dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pm25_reading) &&
      $stable(out_avg_pm25_q4))
    else $error("stalled result transaction changed");

endmodule

bind pm25_frame_parser_averager pfpa_checker u_pfpa_checker (.*);
